/* rtl/banked_work_ram_controller_top_defines.svh */
// Assertion macros shared by the controller RTL.
`ifndef BANKED_WORK_RAM_CONTROLLER_TOP_DEFINES_SVH
`define BANKED_WORK_RAM_CONTROLLER_TOP_DEFINES_SVH

// Checked on every rising clock edge, reset included.
`define BWRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked only while reset is released.
`define BWRC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

/* rtl/bwrc_pkg.sv */
package bwrc_pkg;

    // Field widths.
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int OP_W   = 3;
    localparam int MODE_W = 2;

    // Geometry. Bank size and bank count are powers of two.
    localparam int BANK_BYTES     = 4096;
    localparam int BANK_COUNT     = 256;
    localparam int HIGH_RAM_BYTES = 127;

    localparam int OFF_AW     = $clog2(BANK_BYTES);
    localparam int BANK_AW    = $clog2(BANK_COUNT);
    localparam int WRAM_DEPTH = BANK_COUNT * BANK_BYTES;
    localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
    localparam int HRAM_AW    = $clog2(HIGH_RAM_BYTES);

    // Reciprocal for the high RAM modulo: the estimated quotient is low by at most one.
    localparam int RECIP_SH = 24;
    localparam int RECIP    = (1 << RECIP_SH) / HIGH_RAM_BYTES;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = ADDR_W + RECIP_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRAM_RD = 3'd0;
    localparam logic [OP_W-1:0] OP_WRAM_WR = 3'd1;
    localparam logic [OP_W-1:0] OP_HRAM_RD = 3'd2;
    localparam logic [OP_W-1:0] OP_HRAM_WR = 3'd3;
    localparam logic [OP_W-1:0] OP_BANK_RD = 3'd4;
    localparam logic [OP_W-1:0] OP_BANK_WR = 3'd5;

    // Hardware modes; the unused code behaves as plain mode.
    localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLOUR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXTENDED = 2'd2;

    // Bank register constants.
    localparam logic [DATA_W-1:0] BANK_RESET   = 8'h01;
    localparam logic [DATA_W-1:0] BANK_LOW_MSK = 8'h07;
    localparam logic [DATA_W-1:0] COLOUR_SET   = 8'hF8;
    localparam logic [DATA_W-1:0] DATA_NONE    = 8'hFF;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_MOD    = 5'b00100,
        ST_ACCESS = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

endpackage

/* rtl/bwrc_ram.sv */
module bwrc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port; read data is registered and holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bwrc_hram_mod.sv */
module bwrc_hram_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bwrc_pkg::ADDR_W-1:0] i_address,
    output logic                        o_done,
    output logic [bwrc_pkg::HRAM_AW-1:0] o_index
);

    localparam logic [bwrc_pkg::ADDR_W-1:0] HRB = bwrc_pkg::ADDR_W'(bwrc_pkg::HIGH_RAM_BYTES);

    logic [2:0]                    r_vld;
    logic [bwrc_pkg::ADDR_W-1:0]   r_a1;
    logic [bwrc_pkg::ADDR_W-1:0]   r_a2;
    logic [bwrc_pkg::PROD_W-1:0]   r_prod;
    logic [bwrc_pkg::ADDR_W-1:0]   r_qd;
    logic [bwrc_pkg::HRAM_AW-1:0]  r_idx;
    logic [bwrc_pkg::ADDR_W-1:0]   w_quot;
    logic [bwrc_pkg::ADDR_W-1:0]   w_diff;
    logic [bwrc_pkg::ADDR_W-1:0]   w_rem;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    assign w_quot = bwrc_pkg::ADDR_W'(r_prod >> bwrc_pkg::RECIP_SH);
    assign w_diff = r_a2 - r_qd;
    assign w_rem  = (w_diff >= HRB) ? (w_diff - HRB) : w_diff;

    // Multiply by the reciprocal, multiply back, then one correcting subtract.
    always_ff @(posedge i_clk) begin
        r_a1   <= i_address;
        r_prod <= bwrc_pkg::PROD_W'(i_address) *
                  bwrc_pkg::PROD_W'(bwrc_pkg::RECIP);
        r_a2   <= r_a1;
        r_qd   <= bwrc_pkg::ADDR_W'(w_quot * HRB);
        if (r_vld[1]) begin
            r_idx <= bwrc_pkg::HRAM_AW'(w_rem);
        end
    end

    assign o_done  = r_vld[2];
    assign o_index = r_idx;

endmodule

/* rtl/banked_work_ram_controller_top.sv */
// Channel   Direction  Ports                            Content
// s         in         i_s_tvalid/o_s_tready            tuser: op; tdata: address, write_data
// m         out        o_m_tvalid/i_m_tready            tdata: data_out
// cfg       in         i_cfg_wr_en/i_cfg_wr_data        hardware_mode
//
// One access is handled at a time by a small sequencer around single-port memories.
// Work RAM accesses go through the access state, high RAM accesses first wait on a
// 3-stage modulo unit, and bank register accesses go straight to the final state.
// After reset a clearing pass zeroes both memories over all BANK_COUNT * BANK_BYTES
// work RAM addresses (1048576 at the default sizes); no word is accepted during it.
// A stalled output holds its word; the sequencer waits in its final state meanwhile.
`include "banked_work_ram_controller_top_defines.svh"

module banked_work_ram_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,  // hardware_mode
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,      // [15:0] address, [23:16] write_data
    input  logic [2:0]  i_s_tuser,      // [2:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata       // [7:0] data_out
);

    bwrc_pkg::t_state r_state;
    bwrc_pkg::t_state n_state;

    logic [bwrc_pkg::MODE_W-1:0]  r_mode;
    logic [bwrc_pkg::DATA_W-1:0]  r_bank;
    logic [bwrc_pkg::OP_W-1:0]    r_op;
    logic [bwrc_pkg::ADDR_W-1:0]  r_addr;
    logic [bwrc_pkg::DATA_W-1:0]  r_wdata;
    logic [bwrc_pkg::WRAM_AW-1:0] r_clr_cnt;
    logic                         r_out_valid;
    logic [bwrc_pkg::DATA_W-1:0]  r_out_data;

    logic                          w_accept;
    logic                          w_mod_start;
    logic                          w_out_free;
    logic                          w_finish;
    logic                          w_mod_done;
    logic [bwrc_pkg::HRAM_AW-1:0]  w_hram_idx;
    logic [bwrc_pkg::DATA_W-1:0]   w_bank_raw;
    logic [bwrc_pkg::DATA_W-1:0]   w_bank_eff;
    logic [bwrc_pkg::DATA_W-1:0]   w_result;
    logic                          w_bank_we;
    logic [bwrc_pkg::DATA_W-1:0]   w_bank_next;
    logic                          w_wram_en;
    logic                          w_wram_we;
    logic [bwrc_pkg::WRAM_AW-1:0]  w_wram_addr;
    logic [bwrc_pkg::DATA_W-1:0]   w_wram_wdata;
    logic [bwrc_pkg::DATA_W-1:0]   w_wram_rdata;
    logic                          w_hram_en;
    logic                          w_hram_we;
    logic [bwrc_pkg::HRAM_AW-1:0]  w_hram_addr;
    logic [bwrc_pkg::DATA_W-1:0]   w_hram_wdata;
    logic [bwrc_pkg::DATA_W-1:0]   w_hram_rdata;
    logic                          w_clr_last;
    logic                          w_clr_hram;

    assign o_s_tready = (r_state == bwrc_pkg::ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_finish   = (r_state == bwrc_pkg::ST_DONE) && w_out_free;
    assign w_clr_last = (r_clr_cnt == bwrc_pkg::WRAM_AW'(bwrc_pkg::WRAM_DEPTH - 1));
    assign w_clr_hram = (r_clr_cnt < bwrc_pkg::WRAM_AW'(bwrc_pkg::HIGH_RAM_BYTES));

    // Only high RAM words start the modulo unit, so its done flag belongs to them.
    assign w_mod_start = w_accept && ((i_s_tuser == bwrc_pkg::OP_HRAM_RD) ||
                                      (i_s_tuser == bwrc_pkg::OP_HRAM_WR));

    // Modulo unit for the high RAM index.
    bwrc_hram_mod u_hram_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mod_start),
        .i_address (i_s_tdata[15:0]),
        .o_done    (w_mod_done),
        .o_index   (w_hram_idx)
    );

    // Active bank: chosen by mode, zero taken as one, reduced to the storage.
    always_comb begin
        case (r_mode)
            bwrc_pkg::MODE_EXTENDED: w_bank_raw = r_bank;
            bwrc_pkg::MODE_COLOUR:   w_bank_raw = r_bank & bwrc_pkg::BANK_LOW_MSK;
            default:                 w_bank_raw = bwrc_pkg::BANK_RESET;
        endcase
        w_bank_eff = (w_bank_raw == '0) ? bwrc_pkg::BANK_RESET : w_bank_raw;
    end

    // Memory port drive: the clearing pass, or the one access of the current word.
    always_comb begin
        w_wram_en    = 1'b0;
        w_wram_we    = 1'b0;
        w_wram_addr  = {w_bank_eff[bwrc_pkg::BANK_AW-1:0], r_addr[bwrc_pkg::OFF_AW-1:0]};
        w_wram_wdata = r_wdata;
        w_hram_en    = 1'b0;
        w_hram_we    = 1'b0;
        w_hram_addr  = w_hram_idx;
        w_hram_wdata = r_wdata;
        if (r_state == bwrc_pkg::ST_CLEAR) begin
            w_wram_en    = 1'b1;
            w_wram_we    = 1'b1;
            w_wram_addr  = r_clr_cnt;
            w_wram_wdata = '0;
            w_hram_en    = w_clr_hram;
            w_hram_we    = 1'b1;
            w_hram_addr  = r_clr_cnt[bwrc_pkg::HRAM_AW-1:0];
            w_hram_wdata = '0;
        end else if (r_state == bwrc_pkg::ST_ACCESS) begin
            w_wram_en = (r_op == bwrc_pkg::OP_WRAM_RD) || (r_op == bwrc_pkg::OP_WRAM_WR);
            w_wram_we = (r_op == bwrc_pkg::OP_WRAM_WR);
            w_hram_en = (r_op == bwrc_pkg::OP_HRAM_RD) || (r_op == bwrc_pkg::OP_HRAM_WR);
            w_hram_we = (r_op == bwrc_pkg::OP_HRAM_WR);
        end
    end

    bwrc_ram #(
        .DEPTH (bwrc_pkg::WRAM_DEPTH),
        .WIDTH (bwrc_pkg::DATA_W)
    ) u_wram (
        .i_clk   (i_clk),
        .i_en    (w_wram_en),
        .i_we    (w_wram_we),
        .i_addr  (w_wram_addr),
        .i_wdata (w_wram_wdata),
        .o_rdata (w_wram_rdata)
    );

    bwrc_ram #(
        .DEPTH (bwrc_pkg::HIGH_RAM_BYTES),
        .WIDTH (bwrc_pkg::DATA_W)
    ) u_hram (
        .i_clk   (i_clk),
        .i_en    (w_hram_en),
        .i_we    (w_hram_we),
        .i_addr  (w_hram_addr),
        .i_wdata (w_hram_wdata),
        .o_rdata (w_hram_rdata)
    );

    // Result word and bank register update.
    always_comb begin
        w_result    = bwrc_pkg::DATA_NONE;
        w_bank_we   = 1'b0;
        w_bank_next = r_wdata;
        case (r_op) inside
            bwrc_pkg::OP_WRAM_RD: w_result = w_wram_rdata;
            bwrc_pkg::OP_HRAM_RD: w_result = w_hram_rdata;
            bwrc_pkg::OP_WRAM_WR,
            bwrc_pkg::OP_HRAM_WR: w_result = r_wdata;
            bwrc_pkg::OP_BANK_RD: begin
                case (r_mode)
                    bwrc_pkg::MODE_EXTENDED: w_result = r_bank;
                    bwrc_pkg::MODE_COLOUR:
                        w_result = bwrc_pkg::COLOUR_SET | (r_bank & bwrc_pkg::BANK_LOW_MSK);
                    default:                 w_result = bwrc_pkg::DATA_NONE;
                endcase
            end
            bwrc_pkg::OP_BANK_WR: begin
                case (r_mode)
                    bwrc_pkg::MODE_EXTENDED: begin
                        w_bank_we   = 1'b1;
                        w_bank_next = r_wdata;
                    end
                    bwrc_pkg::MODE_COLOUR: begin
                        w_bank_we   = 1'b1;
                        w_bank_next = bwrc_pkg::COLOUR_SET | (r_wdata & bwrc_pkg::BANK_LOW_MSK);
                    end
                    default: w_bank_we = 1'b0;
                endcase
                w_result = w_bank_we ? w_bank_next : bwrc_pkg::DATA_NONE;
            end
            default: w_result = bwrc_pkg::DATA_NONE;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bwrc_pkg::ST_CLEAR: begin
                if (w_clr_last) n_state = bwrc_pkg::ST_IDLE;
            end
            bwrc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_s_tuser) inside
                        bwrc_pkg::OP_WRAM_RD,
                        bwrc_pkg::OP_WRAM_WR: n_state = bwrc_pkg::ST_ACCESS;
                        bwrc_pkg::OP_HRAM_RD,
                        bwrc_pkg::OP_HRAM_WR: n_state = bwrc_pkg::ST_MOD;
                        default:              n_state = bwrc_pkg::ST_DONE;
                    endcase
                end
            end
            bwrc_pkg::ST_MOD: begin
                if (w_mod_done) n_state = bwrc_pkg::ST_ACCESS;
            end
            bwrc_pkg::ST_ACCESS: n_state = bwrc_pkg::ST_DONE;
            bwrc_pkg::ST_DONE: begin
                if (w_out_free) n_state = bwrc_pkg::ST_IDLE;
            end
            default: n_state = bwrc_pkg::ST_CLEAR;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bwrc_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_mode      <= bwrc_pkg::MODE_PLAIN;
            r_bank      <= bwrc_pkg::BANK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bwrc_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (w_finish && w_bank_we) begin
                r_bank <= w_bank_next;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured word and output data.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_s_tuser;
            r_addr  <= i_s_tdata[15:0];
            r_wdata <= i_s_tdata[23:16];
        end
        if (w_finish) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks on the sequencer and memory ports.
    `BWRC_ASSERT_ALWAYS(a_clear_after_reset, $past(!i_rst_n) |-> (r_state == bwrc_pkg::ST_CLEAR), "sequencer not clearing after reset")
    `BWRC_ASSERT_ALWAYS(a_hram_in_range, w_hram_en |-> (w_hram_addr < bwrc_pkg::HRAM_AW'(bwrc_pkg::HIGH_RAM_BYTES)), "high RAM index out of range")
    `BWRC_ASSERT_RUN(a_one_mem_access, (r_state != bwrc_pkg::ST_CLEAR) |-> !(w_wram_en && w_hram_en), "both memories accessed by one word")
    `BWRC_ASSERT_RUN(a_result_from_done, $rose(o_m_tvalid) |-> $past(r_state == bwrc_pkg::ST_DONE), "result word raised outside the final state")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    // Spare codes that the block must treat as no-ops or as plain mode.
    localparam logic [bwrc_pkg::OP_W-1:0]   OP_SPARE_A = 3'd6;
    localparam logic [bwrc_pkg::OP_W-1:0]   OP_SPARE_B = 3'd7;
    localparam logic [bwrc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PCT     = 9;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int QUIET_PHASE  = 2;
    localparam int HOLD_PHASE   = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int ADDR_POOL    = 24;
    localparam int BANK_POOL    = 3;
    localparam int MAX_PRINTS   = 50;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DIR_ROWS     = 29;

    typedef enum logic {ROW_ACCESS, ROW_MODE} t_row_kind;

    // One row of the directed table; a mode row carries the mode in wdata.
    typedef struct packed {
        t_row_kind                   kind;
        logic [bwrc_pkg::OP_W-1:0]   op;
        logic [bwrc_pkg::ADDR_W-1:0] addr;
        logic [bwrc_pkg::DATA_W-1:0] wdata;
        logic                        fixed;
        logic [bwrc_pkg::DATA_W-1:0] want;
    } t_dir_row;

    typedef struct packed {
        logic [31:0]                 seq;
        logic [bwrc_pkg::DATA_W-1:0] data;
    } t_pending;

    // Clock, reset and DUT-facing signals.
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [1:0]        i_cfg_wr_data = '0;
    logic              i_s_tvalid    = 1'b0;
    logic              o_s_tready;
    logic [23:0]       i_s_tdata     = '0;
    logic [2:0]        i_s_tuser     = '0;
    logic              o_m_tvalid;
    logic              i_m_tready    = 1'b0;
    logic [7:0]        o_m_tdata;

    // Shadow copy of the block state used for prediction.
    bit   [bwrc_pkg::DATA_W-1:0] wram_img [bwrc_pkg::WRAM_DEPTH];
    bit   [bwrc_pkg::DATA_W-1:0] hram_img [bwrc_pkg::HIGH_RAM_BYTES];
    logic [bwrc_pkg::DATA_W-1:0] bank_img;
    logic [bwrc_pkg::MODE_W-1:0] mode_img;

    t_pending          expected_words [$];
    t_pending          head_word;
    int unsigned       word_seq    = 0;
    int unsigned       fail_count  = 0;
    int unsigned       cycle_count = 0;

    // Stimulus control flags, written only by the stimulus process.
    logic              quiet      = 1'b0;
    logic              hold_armed = 1'b0;
    // Hold-off bookkeeping, written only by the receiver process.
    logic              hold_taken = 1'b0;
    int unsigned       hold_left  = 0;

    t_dir_row                    dir_rows [DIR_ROWS];
    logic [bwrc_pkg::ADDR_W-1:0] addr_pool [ADDR_POOL];
    logic [bwrc_pkg::DATA_W-1:0] bank_pool [BANK_POOL];

    banked_work_ram_controller_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Computes the data_out of one access and applies its side effects to the shadow state.
    function automatic logic [bwrc_pkg::DATA_W-1:0] predict_access(
        input logic [bwrc_pkg::OP_W-1:0]   op,
        input logic [bwrc_pkg::ADDR_W-1:0] addr,
        input logic [bwrc_pkg::DATA_W-1:0] wdata);
        int unsigned                  bank;
        logic [bwrc_pkg::WRAM_AW-1:0] wram_idx;
        logic [bwrc_pkg::HRAM_AW-1:0] hram_idx;
        logic [bwrc_pkg::DATA_W-1:0]  data_out;
        case (mode_img)
            bwrc_pkg::MODE_EXTENDED: bank = 32'(bank_img);
            bwrc_pkg::MODE_COLOUR:   bank = 32'(bank_img & bwrc_pkg::BANK_LOW_MSK);
            default:                 bank = 1;
        endcase
        if (bank == 0) begin
            bank = 1;
        end
        bank     = bank % bwrc_pkg::BANK_COUNT;
        wram_idx = bwrc_pkg::WRAM_AW'(bank * bwrc_pkg::BANK_BYTES +
                                      (32'(addr) % bwrc_pkg::BANK_BYTES));
        hram_idx = bwrc_pkg::HRAM_AW'(32'(addr) % bwrc_pkg::HIGH_RAM_BYTES);
        data_out = bwrc_pkg::DATA_NONE;
        case (op)
            bwrc_pkg::OP_WRAM_RD: data_out = wram_img[wram_idx];
            bwrc_pkg::OP_WRAM_WR: begin
                wram_img[wram_idx] = wdata;
                data_out = wdata;
            end
            bwrc_pkg::OP_HRAM_RD: data_out = hram_img[hram_idx];
            bwrc_pkg::OP_HRAM_WR: begin
                hram_img[hram_idx] = wdata;
                data_out = wdata;
            end
            bwrc_pkg::OP_BANK_RD: begin
                if (mode_img == bwrc_pkg::MODE_EXTENDED) begin
                    data_out = bank_img;
                end else if (mode_img == bwrc_pkg::MODE_COLOUR) begin
                    data_out = bwrc_pkg::COLOUR_SET | (bank_img & bwrc_pkg::BANK_LOW_MSK);
                end
            end
            bwrc_pkg::OP_BANK_WR: begin
                if (mode_img == bwrc_pkg::MODE_EXTENDED) begin
                    bank_img = wdata;
                    data_out = wdata;
                end else if (mode_img == bwrc_pkg::MODE_COLOUR) begin
                    bank_img = bwrc_pkg::COLOUR_SET | (wdata & bwrc_pkg::BANK_LOW_MSK);
                    data_out = bank_img;
                end
            end
            default: data_out = bwrc_pkg::DATA_NONE;
        endcase
        return data_out;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
        fail_count++;
    endtask

    // Offers one access word, waits for it to be taken and queues its expected result.
    task automatic send_access(input logic [bwrc_pkg::OP_W-1:0]   op,
                               input logic [bwrc_pkg::ADDR_W-1:0] addr,
                               input logic [bwrc_pkg::DATA_W-1:0] wdata,
                               input logic                        fixed,
                               input logic [bwrc_pkg::DATA_W-1:0] want);
        logic [bwrc_pkg::DATA_W-1:0] predicted;
        t_pending                    entry;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {wdata, addr};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        predicted  = predict_access(op, addr, wdata);
        entry.seq  = word_seq;
        entry.data = fixed ? want : predicted;
        expected_words.push_back(entry);
        word_seq++;
    endtask

    // Changes the hardware mode once every outstanding word has come back.
    task automatic set_mode(input logic [bwrc_pkg::MODE_W-1:0] mode);
        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        mode_img = mode;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Draws one random access biased toward reused addresses and stable banks.
    task automatic send_random_access();
        int unsigned                 pick;
        logic [bwrc_pkg::OP_W-1:0]   op;
        logic [bwrc_pkg::ADDR_W-1:0] addr;
        logic [bwrc_pkg::DATA_W-1:0] wdata;
        pick = $urandom_range(99);
        if (pick < 30) begin
            op = bwrc_pkg::OP_WRAM_RD;
        end else if (pick < 55) begin
            op = bwrc_pkg::OP_WRAM_WR;
        end else if (pick < 67) begin
            op = bwrc_pkg::OP_HRAM_RD;
        end else if (pick < 77) begin
            op = bwrc_pkg::OP_HRAM_WR;
        end else if (pick < 85) begin
            op = bwrc_pkg::OP_BANK_RD;
        end else if (pick < 92) begin
            op = bwrc_pkg::OP_BANK_WR;
        end else if (pick < 96) begin
            op = OP_SPARE_A;
        end else begin
            op = OP_SPARE_B;
        end
        // Pool addresses plus aliases of them, so reads land on earlier writes.
        if ($urandom_range(99) < 60) begin
            addr = addr_pool[$urandom_range(ADDR_POOL - 1)];
            if (op == bwrc_pkg::OP_HRAM_RD || op == bwrc_pkg::OP_HRAM_WR) begin
                addr = addr + bwrc_pkg::ADDR_W'(bwrc_pkg::HIGH_RAM_BYTES * $urandom_range(500));
            end else begin
                addr = addr + bwrc_pkg::ADDR_W'(bwrc_pkg::BANK_BYTES * $urandom_range(15));
            end
        end else begin
            addr = bwrc_pkg::ADDR_W'($urandom_range(16'hFFFF));
        end
        wdata = bwrc_pkg::DATA_W'($urandom_range(8'hFF));
        if (op == bwrc_pkg::OP_BANK_WR) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                wdata = bank_pool[$urandom_range(BANK_POOL - 1)];
            end else if (pick == 6) begin
                wdata = 8'h00;
            end else if (pick == 7) begin
                wdata = 8'hFF;
            end
        end
        send_access(op, addr, wdata, 1'b0, '0);
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off, and a quiet phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (quiet) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker: each taken word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word, data_out %02h", o_m_tdata));
            end else begin
                head_word = expected_words.pop_front();
                if (o_m_tdata !== head_word.data) begin
                    report_mismatch($sformatf("word %0d: data_out %02h, wanted %02h",
                                              head_word.seq, o_m_tdata, head_word.data));
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases across all modes.
    initial begin
        logic [bwrc_pkg::MODE_W-1:0] phase_mode;
        bank_img = bwrc_pkg::BANK_RESET;
        mode_img = bwrc_pkg::MODE_PLAIN;
        dir_rows = '{
            // Plain mode straight after reset.
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_RD, 16'h0000, 8'h00, 1'b1, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_HRAM_RD, 16'hFFFF, 8'h00, 1'b1, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_RD, 16'h0000, 8'h00, 1'b1, bwrc_pkg::DATA_NONE},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'h05, 1'b1, bwrc_pkg::DATA_NONE},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_WR, 16'hFFFF, 8'hFF, 1'b1, 8'hFF},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_RD, 16'h0FFF, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_HRAM_WR, 16'h007E, 8'hA5, 1'b1, 8'hA5},
            '{ROW_ACCESS, bwrc_pkg::OP_HRAM_RD, 16'h00FD, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, OP_SPARE_A, 16'h1234, 8'h77, 1'b1, bwrc_pkg::DATA_NONE},
            '{ROW_ACCESS, OP_SPARE_B, 16'hFFFF, 8'hFF, 1'b1, bwrc_pkg::DATA_NONE},
            // Colour mode: bank 0 maps to 1, high bits forced set.
            '{ROW_MODE,   bwrc_pkg::OP_WRAM_RD, 16'h0000, 8'(bwrc_pkg::MODE_COLOUR), 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_RD, 16'h0000, 8'h00, 1'b1, 8'hF9},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'h00, 1'b1, 8'hF8},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_RD, 16'h0FFF, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'hFF, 1'b1, 8'hFF},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_WR, 16'h1234, 8'h5A, 1'b1, 8'h5A},
            // Extended mode: full 8-bit bank, including 0 and 255.
            '{ROW_MODE,   bwrc_pkg::OP_WRAM_RD, 16'h0000, 8'(bwrc_pkg::MODE_EXTENDED), 1'b0,
              8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_RD, 16'h0000, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'h00, 1'b1, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_RD, 16'h0FFF, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'hFF, 1'b1, 8'hFF},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_WR, 16'h0000, 8'h3C, 1'b1, 8'h3C},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_RD, 16'hF000, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'h80, 1'b1, 8'h80},
            // The unused mode code behaves as plain mode.
            '{ROW_MODE,   bwrc_pkg::OP_WRAM_RD, 16'h0000, 8'(MODE_SPARE), 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_RD, 16'h0000, 8'h00, 1'b1, bwrc_pkg::DATA_NONE},
            '{ROW_ACCESS, bwrc_pkg::OP_BANK_WR, 16'h0000, 8'h12, 1'b1, bwrc_pkg::DATA_NONE},
            '{ROW_ACCESS, bwrc_pkg::OP_WRAM_RD, 16'hFFFF, 8'h00, 1'b0, 8'h00},
            '{ROW_ACCESS, bwrc_pkg::OP_HRAM_RD, 16'h007E, 8'h00, 1'b0, 8'h00}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_MODE) begin
                set_mode(dir_rows[r].wdata[bwrc_pkg::MODE_W-1:0]);
            end else begin
                send_access(dir_rows[r].op, dir_rows[r].addr, dir_rows[r].wdata,
                            dir_rows[r].fixed, dir_rows[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_mode = bwrc_pkg::MODE_COLOUR;
                1:       phase_mode = bwrc_pkg::MODE_EXTENDED;
                2:       phase_mode = bwrc_pkg::MODE_PLAIN;
                3:       phase_mode = bwrc_pkg::MODE_EXTENDED;
                4:       phase_mode = MODE_SPARE;
                5:       phase_mode = bwrc_pkg::MODE_COLOUR;
                6:       phase_mode = bwrc_pkg::MODE_W'($urandom_range(3));
                default: phase_mode = bwrc_pkg::MODE_EXTENDED;
            endcase
            set_mode(phase_mode);
            for (int a = 0; a < ADDR_POOL; a++) begin
                addr_pool[a] = bwrc_pkg::ADDR_W'($urandom_range(16'hFFFF));
            end
            for (int b = 0; b < BANK_POOL; b++) begin
                bank_pool[b] = bwrc_pkg::DATA_W'($urandom_range(8'hFF));
            end
            quiet <= (p == QUIET_PHASE);
            if (p == HOLD_PHASE) begin
                hold_armed <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_access();
            end
        end

        // Let every outstanding word come back, then watch for strays.
        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
